// ===== hdl/dtma_pkg.sv =====
// Shared types, constants and encodings of the detection track merge block.
package dtma_pkg;

   localparam int MaxEntries = 16;
   localparam int SlotW = 4;
   localparam int OccW = 5;

   localparam logic [1:0] ACT_AVERAGED = 2'd0;
   localparam logic [1:0] ACT_MATCHED = 2'd1;
   localparam logic [1:0] ACT_INSERTED = 2'd2;
   localparam logic [1:0] ACT_DROPPED = 2'd3;

   localparam logic CSR_MATCH_RADIUS = 1'b0;
   localparam logic CSR_TARGET_TRACKS = 1'b1;

   typedef struct packed {
      logic [15:0] marker_id;
      logic confident;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic [3:0] slot;
      logic signed [31:0] mean_x;
      logic signed [31:0] mean_y;
      logic signed [31:0] mean_z;
      logic [15:0] sample_count;
      logic [4:0] track_total;
      logic done_res;
   } rsp_type;

   // Classified item handed from the search front to the update back.
   typedef struct packed {
      logic [1:0] action;
      logic [SlotW-1:0] slot;
      req_type item;
   } job_type;

endpackage

// ===== hdl/dtma_div.sv =====
// Restoring divider: signed 49-bit dividend by unsigned 17-bit divisor, truncating.
module dtma_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic signed [48:0] dividend,
   input logic [16:0] divisor,
   output logic busy,
   output logic done,
   output logic signed [31:0] quotient
);
   logic [48:0] rem_ff, rem_in;
   logic [48:0] quo_ff, quo_in;
   logic [16:0] dvs_ff, dvs_in;
   logic neg_ff, neg_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [49:0] trial;
   logic [48:0] mag;
   logic [48:0] qneg;

   assign mag = dividend[48] ? 49'(-dividend) : dividend;
   assign trial = {rem_ff, quo_ff[48]} - {33'd0, dvs_ff};
   assign qneg = 49'(-quo_ff);

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         rem_in = '0;
         quo_in = mag;
         dvs_in = divisor;
         neg_in = dividend[48];
         cnt_in = 6'd49;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit a cycle
         if (!trial[49]) begin
            rem_in = trial[48:0];
            quo_in = {quo_ff[47:0], 1'b1};
         end else begin
            rem_in = {rem_ff[47:0], quo_ff[48]};
            quo_in = {quo_ff[47:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = neg_ff ? qneg[31:0] : quo_ff[31:0];
endmodule

// ===== hdl/dtma_front.sv =====
// Search front: scans the track table and classifies each detection.
module dtma_front (
   input logic clock,
   input logic reset,
   input logic start,
   input dtma_pkg::req_type req,
   output logic front_busy,
   input logic [30:0] match_radius,
   input logic [dtma_pkg::OccW-1:0] occupancy,
   input logic [15:0] id_rd,
   input logic signed [31:0] mx_rd,
   input logic signed [31:0] my_rd,
   output logic [dtma_pkg::SlotW-1:0] rd_slot,
   input logic q_full,
   output logic q_push,
   output dtma_pkg::job_type q_data
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0] st_ff, st_in;
   dtma_pkg::req_type item_ff, item_in;
   logic [dtma_pkg::OccW-1:0] idx_ff, idx_in;
   logic [1:0] act_ff, act_in;
   logic [dtma_pkg::SlotW-1:0] slot_ff, slot_in;
   logic signed [32:0] dx, dy;
   logic [32:0] ax, ay;
   logic hit;

   assign rd_slot = idx_ff[dtma_pkg::SlotW-1:0];
   assign dx = 33'(mx_rd) - 33'(item_ff.pos_x);
   assign dy = 33'(my_rd) - 33'(item_ff.pos_y);
   assign ax = dx[32] ? 33'(-dx) : dx;
   assign ay = dy[32] ? 33'(-dy) : dy;
   assign hit = (id_rd == item_ff.marker_id) ||
                (ax < {2'b00, match_radius} && ay < {2'b00, match_radius});

   always_comb begin
      st_in = st_ff;
      item_in = item_ff;
      idx_in = idx_ff;
      act_in = act_ff;
      slot_in = slot_ff;
      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               item_in = req;
               idx_in = '0;
               st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // occupancy is stable here: the back drains before a new scan
            if (idx_ff >= occupancy) begin
               if (occupancy < dtma_pkg::OccW'(dtma_pkg::MaxEntries)) begin
                  act_in = dtma_pkg::ACT_INSERTED;
                  slot_in = occupancy[dtma_pkg::SlotW-1:0];
               end else begin
                  act_in = dtma_pkg::ACT_DROPPED;
                  slot_in = '0;
               end
               st_in = ST_PUSH;
            end else if (hit) begin
               act_in = item_ff.confident ? dtma_pkg::ACT_AVERAGED
                                          : dtma_pkg::ACT_MATCHED;
               slot_in = idx_ff[dtma_pkg::SlotW-1:0];
               st_in = ST_PUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_PUSH: begin
            if (!q_full) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff <= idx_in;
      act_ff <= act_in;
      slot_ff <= slot_in;
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   assign front_busy = (st_ff != ST_IDLE);
   assign q_push = (st_ff == ST_PUSH) && !q_full;
   assign q_data = '{action: act_ff, slot: slot_ff, item: item_ff};
endmodule

// ===== hdl/dtma_back.sv =====
// Update back: owns the track table, averages, inserts and issues results.
module dtma_back (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input dtma_pkg::job_type q_data,
   output logic q_pop,
   output logic back_busy,
   input logic [4:0] target_tracks,
   output logic [dtma_pkg::OccW-1:0] occupancy,
   input logic [dtma_pkg::SlotW-1:0] rd_slot,
   output logic [15:0] id_rd,
   output logic signed [31:0] mx_rd,
   output logic signed [31:0] my_rd,
   output logic rsp_valid,
   output dtma_pkg::rsp_type rsp
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_DIV = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;
   localparam logic [2:0] ST_MUL = 3'd5;

   logic [15:0] ids_ff [dtma_pkg::MaxEntries];
   logic signed [31:0] mxs_ff [dtma_pkg::MaxEntries];
   logic signed [31:0] mys_ff [dtma_pkg::MaxEntries];
   logic signed [31:0] mzs_ff [dtma_pkg::MaxEntries];
   logic [15:0] cnts_ff [dtma_pkg::MaxEntries];

   logic [2:0] st_ff, st_in;
   dtma_pkg::job_type job_ff;
   logic [dtma_pkg::OccW-1:0] occ_ff;
   logic [1:0] axis_ff;
   logic signed [31:0] old_ff;
   logic [15:0] n_ff;
   logic signed [31:0] res_ff [3];
   logic signed [31:0] p_sel;
   logic signed [48:0] prod_ff;
   logic dstart;
   logic dbusy, ddone;
   logic signed [31:0] dq;
   logic rsp_valid_ff;
   dtma_pkg::rsp_type rsp_ff;
   logic [dtma_pkg::SlotW-1:0] s;
   logic [dtma_pkg::OccW-1:0] occ_new;

   assign s = job_ff.slot;
   assign id_rd = ids_ff[rd_slot];
   assign mx_rd = mxs_ff[rd_slot];
   assign my_rd = mys_ff[rd_slot];
   assign occupancy = occ_ff;

   always_comb begin
      case (axis_ff)
         2'd0: p_sel = job_ff.item.pos_x;
         2'd1: p_sel = job_ff.item.pos_y;
         default: p_sel = job_ff.item.pos_z;
      endcase
   end

   dtma_div u_div (
      .clock(clock), .reset(reset), .start(dstart),
      .dividend(prod_ff + 49'(p_sel)), .divisor({1'b0, n_ff} + 17'd1),
      .busy(dbusy), .done(ddone), .quotient(dq)
   );

   assign dstart = (st_ff == ST_DIV);
   assign occ_new = (job_ff.action == dtma_pkg::ACT_INSERTED) ? occ_ff + 1'b1 : occ_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (q_valid) st_in = ST_READ;
         ST_READ: begin
            if (job_ff.action == dtma_pkg::ACT_AVERAGED) st_in = ST_MUL;
            else st_in = ST_DONE;
         end
         ST_MUL: st_in = ST_DIV;
         ST_DIV: st_in = ST_WAIT;
         ST_WAIT: begin
            if (ddone) st_in = (axis_ff == 2'd2) ? ST_DONE : ST_MUL;
         end
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) job_ff <= q_data;
            axis_ff <= 2'd0;
         end
         ST_READ: begin
            n_ff <= cnts_ff[s];
            old_ff <= mxs_ff[s];
         end
         ST_MUL: begin
            // mean*n, registered before the divider
            prod_ff <= 49'(old_ff) * $signed({1'b0, n_ff});
         end
         ST_WAIT: begin
            if (ddone) begin
               res_ff[axis_ff] <= dq;
               axis_ff <= axis_ff + 2'd1;
               old_ff <= (axis_ff == 2'd0) ? mys_ff[s] : mzs_ff[s];
            end
         end
         ST_DONE: begin
            rsp_ff.action <= job_ff.action;
            rsp_ff.slot <= s;
            rsp_ff.track_total <= occ_new;
            rsp_ff.done_res <= (occ_new >= target_tracks);
            case (job_ff.action)
               dtma_pkg::ACT_AVERAGED: begin
                  mxs_ff[s] <= res_ff[0];
                  mys_ff[s] <= res_ff[1];
                  mzs_ff[s] <= res_ff[2];
                  cnts_ff[s] <= (n_ff == 16'hFFFF) ? n_ff : n_ff + 16'd1;
                  rsp_ff.mean_x <= res_ff[0];
                  rsp_ff.mean_y <= res_ff[1];
                  rsp_ff.mean_z <= res_ff[2];
                  rsp_ff.sample_count <= (n_ff == 16'hFFFF) ? n_ff : n_ff + 16'd1;
               end
               dtma_pkg::ACT_MATCHED: begin
                  rsp_ff.mean_x <= mxs_ff[s];
                  rsp_ff.mean_y <= mys_ff[s];
                  rsp_ff.mean_z <= mzs_ff[s];
                  rsp_ff.sample_count <= cnts_ff[s];
               end
               dtma_pkg::ACT_INSERTED: begin
                  ids_ff[s] <= job_ff.item.marker_id;
                  mxs_ff[s] <= job_ff.item.pos_x;
                  mys_ff[s] <= job_ff.item.pos_y;
                  mzs_ff[s] <= job_ff.item.pos_z;
                  cnts_ff[s] <= 16'd1;
                  rsp_ff.mean_x <= job_ff.item.pos_x;
                  rsp_ff.mean_y <= job_ff.item.pos_y;
                  rsp_ff.mean_z <= job_ff.item.pos_z;
                  rsp_ff.sample_count <= 16'd1;
               end
               default: begin
                  rsp_ff.mean_x <= '0;
                  rsp_ff.mean_y <= '0;
                  rsp_ff.mean_z <= '0;
                  rsp_ff.sample_count <= '0;
               end
            endcase
         end
         default: ;
      endcase
      rsp_valid_ff <= !reset && (st_ff == ST_DONE);
      if (reset) begin
         st_ff <= ST_IDLE;
         occ_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_DONE) occ_ff <= occ_new;
      end
   end

   assign q_pop = (st_ff == ST_IDLE) && q_valid;
   assign back_busy = (st_ff != ST_IDLE) || dbusy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
endmodule

// ===== hdl/dtma_queue.sv =====
// Two-entry job queue between the search front and the update back.
module dtma_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input dtma_pkg::job_type push_data,
   output logic full,
   input logic pop,
   output logic valid,
   output dtma_pkg::job_type pop_data
);
   dtma_pkg::job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign full = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign pop_data = mem_ff[rp_ff];
endmodule

// ===== hdl/detection_track_merge_average_top.sv =====
// Top level of the detection track merge and average block.
//
//   channel  direction  handshake                      payload
//   req      in         start & !busy                  req (dtma_pkg::req_type)
//   rsp      out        rsp_valid, one cycle, no stall rsp (dtma_pkg::rsp_type)
//   csr      in         csr_we                         csr_index, csr_wdata[30:0]
//
// One item at a time. The front scans one stored track per cycle until a hit
// or the end of the table, then pushes the item into the queue, and the back
// pops it when idle and reads the slot. A confident match runs three divisions,
// one per axis, each as a multiply, a divider start, one divider step per
// dividend bit and the done; other actions go from the read straight to done.
// busy stays high from acceptance through the strobe cycle and drops after.
// Reset clears occupancy and all control; table contents need no clearing.
// The queue never fills with one item in flight and the receiver cannot stall.
module detection_track_merge_average_top (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input dtma_pkg::req_type req,
   output logic rsp_valid,
   output dtma_pkg::rsp_type rsp,
   input logic csr_we,
   input logic csr_index,
   input logic [30:0] csr_wdata
);
   logic [30:0] radius_ff;
   logic [4:0] target_ff;
   logic front_busy, back_busy;
   logic [dtma_pkg::OccW-1:0] occupancy;
   logic [dtma_pkg::SlotW-1:0] rd_slot;
   logic [15:0] id_rd;
   logic signed [31:0] mx_rd, my_rd;
   logic q_full, q_push, q_pop, q_valid;
   dtma_pkg::job_type q_in, q_out;
   logic pend_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 31'd13107;
         target_ff <= 5'd3;
      end else if (csr_we) begin
         case (csr_index)
            dtma_pkg::CSR_MATCH_RADIUS: radius_ff <= csr_wdata;
            dtma_pkg::CSR_TARGET_TRACKS: target_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // hold busy from acceptance until the result goes out
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else if (start && !busy) pend_ff <= 1'b1;
      else if (rsp_valid) pend_ff <= 1'b0;
   end
   assign busy = pend_ff || front_busy || back_busy;

   dtma_front u_front (
      .clock(clock), .reset(reset), .start(start && !busy), .req(req),
      .front_busy(front_busy), .match_radius(radius_ff), .occupancy(occupancy),
      .id_rd(id_rd), .mx_rd(mx_rd), .my_rd(my_rd), .rd_slot(rd_slot),
      .q_full(q_full), .q_push(q_push), .q_data(q_in)
   );

   dtma_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in),
      .full(q_full), .pop(q_pop), .valid(q_valid), .pop_data(q_out)
   );

   dtma_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_out),
      .q_pop(q_pop), .back_busy(back_busy), .target_tracks(target_ff),
      .occupancy(occupancy), .rd_slot(rd_slot), .id_rd(id_rd),
      .mx_rd(mx_rd), .my_rd(my_rd), .rsp_valid(rsp_valid), .rsp(rsp)
   );
endmodule

// ===== hdl/dtma_checker.sv =====
// Port-level checker for the detection track merge block, with its bind.
module dtma_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic [1:0] rsp_action,
   input logic [3:0] rsp_slot,
   input logic [15:0] rsp_count,
   input logic [4:0] rsp_total
);
   a_rsp_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result without pending item");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == dtma_pkg::ACT_DROPPED) |-> (rsp_slot == 4'd0 &&
      rsp_count == 16'd0 && rsp_total == 5'd16)) else $error("bad drop result");
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == dtma_pkg::ACT_INSERTED) |-> (rsp_count == 16'd1 &&
      rsp_total == 5'(rsp_slot) + 5'd1)) else $error("bad insert result");
endmodule

bind detection_track_merge_average_top dtma_checker u_dtma_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_action(rsp.action), .rsp_slot(rsp.slot),
   .rsp_count(rsp.sample_count), .rsp_total(rsp.track_total)
);
